/* src/rba_pkg.sv */
// shared types and constants for the ring-bin path search block
// no dependencies; used by rba_ctrl, rba_dp, ring_bin_astar_path, the checker and tb
package rba_pkg;

  localparam int BINS_DEF = 64;
  localparam int FIELD_W  = 6;
  localparam int MASK_W   = 64;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 4;

  // register map, 8 bytes per register
  localparam logic [ADDR_W-1:0] ADDR_GOAL = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_MASK = 4'h8;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic decide;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic last_word;
  } dp_status_t;

endpackage

/* src/ring_bin_astar_path.sv */
// top level of the ring-bin path search: apb register file, controller, datapath
// depends on rba_pkg, rba_ctrl and rba_dp
// usage
//   a request word carries origin_bin on the in channel (in_valid / in_ready).
//   the block walks both arcs of the ring towards target_bin, avoids blocked bins,
//   and returns the shorter free arc on the out channel, one word per bin,
//   start bin first, last set on the final word. ties take the increasing arc.
//   no free arc, out-of-range bin, blocked goal off start: one word, found = 0.
//   target_bin (address 0x0) and obstacle_mask (address 0x8) are written over
//   the apb port while the block is idle; both read back.
// sequence
//   the request is taken, then the scan runs over the longer of the two arc
//   lengths (no scan for start on goal, a blocked goal or an out-of-range bin),
//   then the arc is picked, then hops + 1 words go out at one per cycle unless
//   the receiver stalls; the two arc walkers step one bin per cycle and set the
//   scan length.
// reset and stall
//   rst clears the controller, the output valid and both registers to zero.
//   a stalled receiver holds the output word; the walker waits with it.
//   a new request is taken while the final word of the previous one waits.
module ring_bin_astar_path
  import rba_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // request words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] origin_bin,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] path_bin,
  output logic               found,
  output logic               last
);

  logic [FIELD_W-1:0] target_bin;
  logic [MASK_W-1:0]  obstacle_mask;
  logic               cfg_wr;
  dp_cmd_t            cmd;
  dp_status_t         st;

  // apb register file, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_bin    <= '0;
      obstacle_mask <= '0;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_GOAL: target_bin    <= pwdata[FIELD_W-1:0];
        ADDR_MASK: obstacle_mask <= pwdata[MASK_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_GOAL: prdata = DATA_W'(target_bin);
      ADDR_MASK: prdata = DATA_W'(obstacle_mask);
      default:   prdata = '0;
    endcase
  end

  // sequencing of load, scan, arc choice and word output
  rba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // arc walkers, path walker and output register
  rba_dp #(
    .BINS (BINS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .origin_bin    (origin_bin),
    .target_bin    (target_bin),
    .obstacle_mask (obstacle_mask),
    .path_bin      (path_bin),
    .found         (found),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  // a no-path word is always the only word of its request
  a_nopath_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last)
    else $error("no-path word without last");

  // one request in flight: ready drops straight after a request is taken
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a path keeps streaming: the next word follows as soon as one is taken
  a_path_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && found && !last |=> out_valid)
    else $error("gap inside path output");

endmodule

/* src/rba_ctrl.sv */
// controller state machine for the ring-bin path search
// depends on rba_pkg (command and status structs)
module rba_ctrl
  import rba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          cmd.decide = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last_word) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/rba_dp.sv */
// datapath for the ring-bin path search: arc walkers, path walker, output register
// depends on rba_pkg (command and status structs, field widths)
module rba_dp
  import rba_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         st,
  input  logic [FIELD_W-1:0] origin_bin,
  input  logic [FIELD_W-1:0] target_bin,
  input  logic [MASK_W-1:0]  obstacle_mask,
  output logic [FIELD_W-1:0] path_bin,
  output logic               found,
  output logic               last,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CNT_W = BIN_W + 1;
  localparam logic [CNT_W-1:0]   BINS_C = CNT_W'(BINS);
  localparam logic [BIN_W-1:0]   TOP_BIN = BIN_W'(BINS - 1);
  localparam logic [FIELD_W:0]   BINS_F = (FIELD_W + 1)'(BINS);

  function automatic logic [BIN_W-1:0] bin_inc(input logic [BIN_W-1:0] b);
    return (b == TOP_BIN) ? '0 : b + BIN_W'(1);
  endfunction

  function automatic logic [BIN_W-1:0] bin_dec(input logic [BIN_W-1:0] b);
    return (b == '0) ? TOP_BIN : b - BIN_W'(1);
  endfunction

  logic [BINS-1:0]  mask_bins;
  logic [BIN_W-1:0] s_in, g_in;
  logic             oor_in, same_in;
  logic [CNT_W-1:0] up_in, down_in;

  // request registers
  logic [BIN_W-1:0] s_pos;
  logic             special, special_found;
  logic [CNT_W-1:0] up_len, down_len, kmax, k;
  logic [BIN_W-1:0] up_pos, down_pos;
  logic             up_blk, down_blk;

  // path walker
  logic             dir_up, path_found;
  logic [BIN_W-1:0] emit_pos, rem;

  assign mask_bins = obstacle_mask[BINS-1:0];
  assign s_in      = origin_bin[BIN_W-1:0];
  assign g_in      = target_bin[BIN_W-1:0];
  assign oor_in    = ({1'b0, origin_bin} >= BINS_F) || ({1'b0, target_bin} >= BINS_F);
  assign same_in   = (origin_bin == target_bin);
  assign up_in     = (g_in >= s_in) ? (CNT_W'(g_in) - CNT_W'(s_in))
                                    : (CNT_W'(g_in) + BINS_C - CNT_W'(s_in));
  assign down_in   = BINS_C - up_in;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_pos         <= s_in;
      special       <= oor_in || same_in || mask_bins[g_in];
      special_found <= !oor_in && same_in;
      up_len        <= up_in;
      down_len      <= down_in;
      kmax          <= (up_in > down_in) ? up_in : down_in;
      k             <= CNT_W'(1);
      up_pos        <= bin_inc(s_in);
      down_pos      <= bin_dec(s_in);
      up_blk        <= 1'b0;
      down_blk      <= 1'b0;
    end else if (cmd.step) begin
      if (k <= up_len) begin
        up_blk <= up_blk || mask_bins[up_pos];
      end
      if (k <= down_len) begin
        down_blk <= down_blk || mask_bins[down_pos];
      end
      k        <= k + CNT_W'(1);
      up_pos   <= bin_inc(up_pos);
      down_pos <= bin_dec(down_pos);
    end
  end

  // arc choice; ties go to the increasing direction
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      emit_pos <= s_pos;
      dir_up   <= 1'b1;
      if (special) begin
        path_found <= special_found;
        rem        <= '0;
      end else if (!up_blk && (down_blk || up_len <= down_len)) begin
        path_found <= 1'b1;
        rem        <= up_len[BIN_W-1:0];
      end else if (!down_blk) begin
        path_found <= 1'b1;
        rem        <= down_len[BIN_W-1:0];
        dir_up     <= 1'b0;
      end else begin
        path_found <= 1'b0;
        rem        <= '0;
      end
    end else if (cmd.emit) begin
      emit_pos <= dir_up ? bin_inc(emit_pos) : bin_dec(emit_pos);
      rem      <= rem - BIN_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      path_bin <= FIELD_W'(emit_pos);
      found    <= path_found;
      last     <= (rem == '0);
    end
  end

  assign st.scan_done = special || (k > kmax);
  assign st.out_free  = !out_valid || out_ready;
  assign st.last_word = (rem == '0);

endmodule

/* dv/ring_bin_path_checker.sv */
// checker for the ring-bin path search: tracks the register writes, predicts the
// path words for each accepted request and compares them on the result channel
// depends on rba_pkg only
module ring_bin_path_checker
  import rba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FIELD_W-1:0] origin_bin,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [FIELD_W-1:0] path_bin,
  input  logic               found,
  input  logic               last,
  output int                 fail_count,
  output int                 pending,
  output int                 req_total,
  output int                 word_total,
  output int                 nopath_total
);

  localparam int RING       = BINS_DEF;
  localparam int ERR_SHOWN  = 40;

  typedef struct packed {
    logic [FIELD_W-1:0] bin;
    logic               found;
    logic               last;
  } path_word_t;

  logic [FIELD_W-1:0] goal_sh;
  logic [MASK_W-1:0]  mask_sh;
  path_word_t         route_due[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    req_total    = 0;
    word_total   = 0;
    nopath_total = 0;
    goal_sh      = '0;
    mask_sh      = '0;
  end

  task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
    fail_count++;
    if (fail_count <= ERR_SHOWN)
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
  endtask

  // append one expected word at the tail of the queue
  task automatic due_add(input path_word_t w);
    route_due.insert(route_due.size(), w);
  endtask

  // every bin entered along the arc must be free; the start bin is skipped
  function automatic bit arc_clear(input int from, input int hops, input bit upward);
    int b;
    b = from;
    for (int i = 0; i < hops; i++) begin
      b = (b + (upward ? 1 : RING - 1)) % RING;
      if (mask_sh[b]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic no_route(input logic [FIELD_W-1:0] from);
    nopath_total++;
    due_add('{from, 1'b0, 1'b1});
  endtask

  task automatic plan_route(input logic [FIELD_W-1:0] from);
    int up;
    int dn;
    int hops;
    int step;
    int b;
    bit up_ok;
    bit dn_ok;
    req_total++;
    if (from == goal_sh) begin
      due_add('{from, 1'b1, 1'b1});
      return;
    end
    if (mask_sh[goal_sh]) begin
      no_route(from);
      return;
    end
    up    = (int'(goal_sh) + RING - int'(from)) % RING;
    dn    = RING - up;
    up_ok = arc_clear(from, up, 1'b1);
    dn_ok = arc_clear(from, dn, 1'b0);
    if (up_ok && (!dn_ok || up <= dn)) begin
      hops = up;
      step = 1;
    end else if (dn_ok) begin
      hops = dn;
      step = RING - 1;
    end else begin
      no_route(from);
      return;
    end
    b = from;
    for (int k = 0; k <= hops; k++) begin
      due_add('{b[FIELD_W-1:0], 1'b1, k == hops});
      b = (b + step) % RING;
    end
  endtask

  always @(posedge clk) begin : watch
    path_word_t due;
    if (rst) begin
      pending <= 0;
    end else begin
      // register file shadow and read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_GOAL) goal_sh = pwdata[FIELD_W-1:0];
          else if (paddr == ADDR_MASK) mask_sh = pwdata[MASK_W-1:0];
        end else if (paddr == ADDR_GOAL) begin
          if (prdata !== DATA_W'(goal_sh))
            flag("target_bin readback", 64'(goal_sh), prdata);
        end else if (paddr == ADDR_MASK) begin
          if (prdata !== DATA_W'(mask_sh))
            flag("obstacle_mask readback", mask_sh, prdata);
        end
      end
      // older request drains first, so compare before queuing the new one
      if (out_valid && out_ready) begin
        word_total++;
        if (route_due.size() == 0) begin
          fail_count++;
          if (fail_count <= ERR_SHOWN)
            $error("word with nothing due: path_bin %0d found %0b last %0b",
                   path_bin, found, last);
        end else begin
          due = route_due.pop_front();
          if (path_bin !== due.bin)  flag("path_bin", 64'(due.bin), 64'(path_bin));
          if (found !== due.found)   flag("found", 64'(due.found), 64'(found));
          if (last !== due.last)     flag("last", 64'(due.last), 64'(last));
        end
      end
      if (in_valid && in_ready) plan_route(origin_bin);
      pending <= route_due.size();
    end
  end

endmodule

/* dv/tb.sv */
// testbench top for ring_bin_astar_path: clock, reset, apb set-up, request and
// result handshakes with random idling; checking sits in ring_bin_path_checker
// depends on rba_pkg, ring_bin_astar_path and ring_bin_path_checker
module tb;
  import rba_pkg::*;

  localparam int TAIL      = 2 * BINS_DEF + 8;   // longest scan plus pick, with margin
  localparam int LIMIT     = 6_000_000;          // several times the slowest correct run
  localparam int RAND_SETS = 10;
  localparam int RAND_REQS = 21;

  logic               clk;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [ADDR_W-1:0]  paddr     = '0;
  logic [DATA_W-1:0]  pwdata    = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] origin_bin = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] path_bin;
  logic               found;
  logic               last;

  int fail_count;
  int pending;
  int req_total;
  int word_total;
  int nopath_total;

  // stimulus-side view of the goal, only used to aim start bins near it
  logic [FIELD_W-1:0] goal_now = '0;
  int                 settings = 0;
  // when set, both sides run flat out with no idle cycles
  bit                 calm     = 1'b0;

  ring_bin_astar_path DUT (.*);

  ring_bin_path_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT);
    $display("timeout: run did not drain, %0d words still due", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // request sender: valid stays up across back-to-back words, dropped only for a gap
  task automatic send_start(input logic [FIELD_W-1:0] s);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    origin_bin <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and let every due word arrive before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // write then read back one register; psel is left high for the caller to drop
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_config(input logic [FIELD_W-1:0] goal, input logic [MASK_W-1:0] mask);
    write_reg(ADDR_GOAL, DATA_W'(goal));
    write_reg(ADDR_MASK, DATA_W'(mask));
    psel     <= 1'b0;
    penable  <= 1'b0;
    goal_now  = goal;
    settings++;
  endtask

  // a handful of blocked bins, the usual shape for a route that exists
  function automatic logic [MASK_W-1:0] sparse_mask();
    logic [MASK_W-1:0] m;
    int n;
    m = '0;
    n = $urandom_range(1, 4);
    repeat (n) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
    return m;
  endfunction

  // mostly uniform start bins, some aimed at the goal and its neighbours
  function automatic logic [FIELD_W-1:0] pick_start();
    case ($urandom_range(0, 9))
      0:       return goal_now;
      1:       return goal_now + FIELD_W'(1);
      2:       return goal_now - FIELD_W'(1);
      default: return FIELD_W'($urandom_range(0, BINS_DEF - 1));
    endcase
  endfunction

  // result receiver: ready dropped only for a drawn stall, one draw per word
  initial begin : drain
    int gap;
    @(posedge clk);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] goal;
    logic [MASK_W-1:0]  mask;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset: goal 0, nothing blocked
    // start on goal, one hop up from 63, one hop down from 1, equal-arc tie and neighbours
    send_start(6'd0);
    send_start(6'd63);
    send_start(6'd1);
    send_start(6'd32);
    send_start(6'd31);
    send_start(6'd33);

    // every bin blocked: start on a blocked goal still finds, otherwise no route
    wait_idle();
    set_config(6'd63, '1);
    send_start(6'd63);
    send_start(6'd0);
    send_start(6'd5);

    // shorter arc blocked so the long way round is taken; blocked start is never checked
    wait_idle();
    set_config(6'd10, MASK_W'(1) << 20);
    send_start(6'd25);
    send_start(6'd5);
    send_start(6'd20);

    // obstacles on both sides: both arcs shut, or one side open
    wait_idle();
    set_config(6'd40, (MASK_W'(1) << 30) | (MASK_W'(1) << 50));
    send_start(6'd0);
    send_start(6'd45);
    send_start(6'd35);
    send_start(6'd31);

    // neighbour blocked, forcing the longest route of 62 hops
    wait_idle();
    set_config(6'd2, MASK_W'(1) << 1);
    send_start(6'd0);
    send_start(6'd3);
    send_start(6'd1);

    // random settings, most with the goal left free so real routes come out
    for (int p = 0; p < RAND_SETS; p++) begin
      wait_idle();
      case (p)
        0:       goal = '0;
        1:       goal = '1;
        default: goal = FIELD_W'($urandom_range(0, BINS_DEF - 1));
      endcase
      case (p % 5)
        0:       mask = '0;
        2:       mask = {$urandom, $urandom};
        4:       mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        default: mask = sparse_mask();
      endcase
      if (p == RAND_SETS - 1) mask = '1;
      else if ($urandom_range(0, 4) != 0) mask[goal] = 1'b0;
      set_config(goal, mask);
      calm = (p % 3 == 2);
      repeat (RAND_REQS) send_start(pick_start());
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);

    $display("covered %0d requests over %0d register settings plus reset values",
             req_total, settings);
    $display("checked %0d path words, %0d requests ended with no route",
             word_total, nopath_total);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
